### hw/rtl/mlk_pkg.sv
// Package for the Morse letter keyer: segment types, register indexes,
// reset values and the letter code table. No dependencies.
package mlk_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_DOT_TIME   = 2'd0;
  localparam logic [1:0] REG_DASH_TIME  = 2'd1;
  localparam logic [1:0] REG_LETTER_GAP = 2'd2;

  // Register reset values
  localparam logic [15:0] DOT_TIME_RST   = 16'd200;
  localparam logic [15:0] DASH_TIME_RST  = 16'd1000;
  localparam logic [15:0] LETTER_GAP_RST = 16'd500;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Which register supplies a segment's duration
  typedef enum logic [1:0] {
    DUR_DOT  = 2'd0,
    DUR_DASH = 2'd1,
    DUR_GAP  = 2'd2
  } dur_sel_e;

  // One segment descriptor from the sequencer
  typedef struct packed {
    logic     level;
    dur_sel_e dur;
    logic     last;
  } seg_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic busy;
    logic final_seg;
  } seq_status_t;

  // Per letter: [6:4] symbol count, [3:0] symbols, first symbol in the
  // highest used bit, 1 = dash.
  typedef logic [6:0] code_entry_t;

  localparam code_entry_t CODE_TABLE [26] = '{
    {3'd2, 4'h1}, {3'd4, 4'h8}, {3'd4, 4'hA}, {3'd3, 4'h4}, {3'd1, 4'h0},
    {3'd4, 4'h2}, {3'd3, 4'h6}, {3'd4, 4'h0}, {3'd2, 4'h0}, {3'd4, 4'h7},
    {3'd3, 4'h5}, {3'd4, 4'h4}, {3'd2, 4'h3}, {3'd2, 4'h2}, {3'd3, 4'h7},
    {3'd4, 4'h6}, {3'd4, 4'hD}, {3'd3, 4'h2}, {3'd3, 4'h0}, {3'd1, 4'h1},
    {3'd3, 4'h1}, {3'd4, 4'h1}, {3'd3, 4'h3}, {3'd4, 4'h9}, {3'd4, 4'hB},
    {3'd4, 4'hC}
  };

endpackage

### hw/rtl/morse_letter_keyer_core.sv
// Morse letter keyer: one character beat in, one beat per keyed segment out.
// The first segment (letter gap) is registered in mlk_seq, then in mlk_out_stage.
// Throughput: one segment per cycle while the output is ready; a character has
// 2 to 8 segments (2 for non-letters, twice the symbol count otherwise).
// Reset: asynchronous, active low; timing registers return to 200/1000/500.
// Depends on mlk_pkg, mlk_seq and mlk_out_stage.
module morse_letter_keyer_core import mlk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Character input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  // Segment output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] duration
  output logic        m_axis_tuser_o,   // [0] level
  output logic        m_axis_tlast_o
);

  logic [15:0] dot_time_q, dash_time_q, letter_gap_q;
  logic        adv;
  logic        seg_valid;
  seg_t        seg;
  seq_status_t status;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_time_q   <= DOT_TIME_RST;
      dash_time_q  <= DASH_TIME_RST;
      letter_gap_q <= LETTER_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DOT_TIME:   dot_time_q   <= cfg_wdata_i;
        REG_DASH_TIME:  dash_time_q  <= cfg_wdata_i;
        REG_LETTER_GAP: letter_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mlk_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_code_i (s_axis_tdata_i),
    .adv_i       (adv),
    .seg_valid_o (seg_valid),
    .seg_o       (seg),
    .status_o    (status)
  );

  mlk_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_valid_i  (seg_valid),
    .seg_i        (seg),
    .dot_time_i   (dot_time_q),
    .dash_time_i  (dash_time_q),
    .letter_gap_i (letter_gap_q),
    .adv_o        (adv),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .duration_o   (m_axis_tdata_o),
    .level_o      (m_axis_tuser_o),
    .last_o       (m_axis_tlast_o)
  );

`ifndef NO_ASSERTIONS
  // An idle sequencer always takes a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.busy |-> s_axis_tready_o)
    else $error("keyer idle but not ready");

  // A new character only overlaps the final segment of the previous one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && status.busy) |-> (status.final_seg && adv))
    else $error("character accepted mid-sequence");

  // After the final segment moves out with no new beat, the sequencer goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.busy && status.final_seg && adv && !s_axis_tvalid_i) |=> !status.busy)
    else $error("sequencer did not retire its character");
`endif

endmodule

### hw/rtl/mlk_seq.sv
// Input register and segment sequencer of the Morse letter keyer.
// Depends on mlk_pkg.
module mlk_seq import mlk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        adv_i,       // output stage takes a segment this cycle
  output logic        seg_valid_o,
  output seg_t        seg_o,
  output seq_status_t status_o
);

  logic       busy_q, busy_d;
  logic [2:0] k_q, k_d;
  logic       letter_q, letter_d;
  logic [2:0] count_q, count_d;
  logic [3:0] bits_q, bits_d;

  logic [7:0]  folded;
  logic [7:0]  offs;
  code_entry_t entry;
  logic [2:0]  last_idx;
  logic        final_seg;
  logic        accept;
  logic [2:0]  shift;
  logic        is_dash;

  // Fold case and look up the letter
  always_comb begin
    folded = char_code_i;
    if (char_code_i inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      folded = char_code_i + CASE_OFFSET;
    end
    letter_d = folded inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
    offs     = folded - CHAR_LOWER_A;
    entry    = letter_d ? CODE_TABLE[offs[4:0]] : '0;
    count_d  = entry[6:4];
    bits_d   = entry[3:0];
  end

  // Final segment index: two per symbol less one for letters, one otherwise
  assign last_idx  = letter_q ? {count_q[1:0], 1'b0} - 3'd1 : 3'd1;
  assign final_seg = (k_q == last_idx);

  assign in_ready_o = !busy_q || (final_seg && adv_i);
  assign accept     = in_valid_i && in_ready_o;

  // Control state
  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (accept) begin
      busy_d = 1'b1;
      k_d    = '0;
    end else if (busy_q && adv_i) begin
      if (final_seg) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      letter_q <= letter_d;
      count_q  <= count_d;
      bits_q   <= bits_d;
    end
  end

  // Segment: gap, then letter symbols with dot spaces, else a dash space
  assign shift   = count_q - 3'd1 - {1'b0, k_q[2:1]};
  assign is_dash = bits_q[shift[1:0]];

  always_comb begin
    seg_o.level = 1'b0;
    seg_o.dur   = DUR_GAP;
    seg_o.last  = final_seg;
    if (k_q == 3'd0) begin
      seg_o.last = 1'b0;
    end else if (!letter_q) begin
      seg_o.dur = DUR_DASH;
    end else if (k_q[0]) begin
      seg_o.level = 1'b1;
      seg_o.dur   = is_dash ? DUR_DASH : DUR_DOT;
    end else begin
      seg_o.dur = DUR_DOT;
    end
  end

  assign seg_valid_o        = busy_q;
  assign status_o.busy      = busy_q;
  assign status_o.final_seg = final_seg;

endmodule

### hw/rtl/mlk_out_stage.sv
// Output register of the Morse letter keyer: resolves the segment duration
// from the timing registers and holds the beat. Depends on mlk_pkg.
module mlk_out_stage import mlk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seg_valid_i,
  input  seg_t        seg_i,
  input  logic [15:0] dot_time_i,
  input  logic [15:0] dash_time_i,
  input  logic [15:0] letter_gap_i,
  output logic        adv_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] duration_o,
  output logic        level_o,
  output logic        last_o
);

  logic        valid_q;
  logic [15:0] dur_q, dur_d;
  logic        level_q, last_q;

  assign adv_o = !valid_q || ready_i;

  // Duration select
  always_comb begin
    case (seg_i.dur)
      DUR_DOT:  dur_d = dot_time_i;
      DUR_DASH: dur_d = dash_time_i;
      DUR_GAP:  dur_d = letter_gap_i;
      default:  dur_d = letter_gap_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= seg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && seg_valid_i) begin
      dur_q   <= dur_d;
      level_q <= seg_i.level;
      last_q  <= seg_i.last;
    end
  end

  assign valid_o    = valid_q;
  assign duration_o = dur_q;
  assign level_o    = level_q;
  assign last_o     = last_q;

endmodule

### verif/morse_letter_keyer_core_tb.sv
// Self-checking testbench for morse_letter_keyer_core: drives characters, predicts
// every keyed segment and checks each output beat against it.
// Depends on mlk_pkg and the morse_letter_keyer_core RTL.
module morse_letter_keyer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlk_pkg::*;

  localparam int          CLK_HALF       = 10;
  localparam int          RESET_CYCLES   = 8;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [1:0]  REG_UNUSED     = 2'd3;

  // Expected segment, same fields as one output beat
  typedef struct packed {
    logic        level;
    logic [15:0] duration;
    logic        last;
  } segment_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_idx     = REG_DOT_TIME;
  logic [15:0] cfg_wdata   = '0;
  logic        char_valid  = 1'b0;
  logic [7:0]  char_data   = '0;
  logic        seg_ready   = 1'b0;
  logic        char_ready;
  logic        seg_valid;
  logic [15:0] seg_duration;
  logic        seg_level;
  logic        seg_last;

  // Predictor copy of the timing registers
  logic [15:0] dot_model;
  logic [15:0] dash_model;
  logic [15:0] gap_model;

  segment_t    pending_segs [$];
  int          fail_count   = 0;
  int          stall_cycles = 0;
  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;

  // Dots and dashes for a..z
  string morse_symbols [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  morse_letter_keyer_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (char_valid),
    .s_axis_tready_o (char_ready),
    .s_axis_tdata_i  (char_data),
    .m_axis_tvalid_o (seg_valid),
    .m_axis_tready_i (seg_ready),
    .m_axis_tdata_o  (seg_duration),
    .m_axis_tuser_o  (seg_level),
    .m_axis_tlast_o  (seg_last)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Queue up the segments one character should produce
  function automatic void predict_segments(input logic [7:0] code);
    logic [7:0] c;
    string      sym;
    c = code;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = c + CASE_OFFSET;
    pending_segs.push_back('{1'b0, gap_model, 1'b0});
    if (c < CHAR_LOWER_A || c > CHAR_LOWER_Z) begin
      pending_segs.push_back('{1'b0, dash_model, 1'b1});
      return;
    end
    sym = morse_symbols[c - CHAR_LOWER_A];
    for (int i = 0; i < sym.len(); i++) begin
      if (i > 0) pending_segs.push_back('{1'b0, dot_model, 1'b0});
      pending_segs.push_back('{1'b1, (sym[i] == "-") ? dash_model : dot_model,
                               (i == sym.len() - 1)});
    end
  endfunction

  // Compare one output beat with the oldest expectation
  task automatic check_segment();
    segment_t want;
    if (pending_segs.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("[%0t] unexpected segment: level=%0b duration=%0d last=%0b",
                 $realtime, seg_level, seg_duration, seg_last);
      return;
    end
    want = pending_segs.pop_front();
    if (want.level !== seg_level || want.duration !== seg_duration ||
        want.last !== seg_last) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("[%0t] segment mismatch: exp level=%0b duration=%0d last=%0b, %s%0b %s%0d %s%0b",
                 $realtime, want.level, want.duration, want.last,
                 "got level=", seg_level, "duration=", seg_duration,
                 "last=", seg_last);
    end
  endtask

  // Output side: random backpressure, checking and stall counting
  always @(posedge clk_i) begin
    if (rst_ni && seg_valid && seg_ready) check_segment();
    if ((char_valid && char_ready) || (seg_valid && seg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    seg_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Watchdog: no beat on either side for too long
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // Send one character beat; valid stays high for a following call
  task automatic key_char(input logic [7:0] code);
    while ($urandom_range(99) < src_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk_i);
    end
    char_valid <= 1'b1;
    char_data  <= code;
    @(posedge clk_i);
    while (!char_ready) @(posedge clk_i);
    predict_segments(code);
  endtask

  task automatic release_input();
    char_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_segments_done();
    while (pending_segs.size() != 0) @(posedge clk_i);
  endtask

  // Idle the block so the timing registers can change
  task automatic wait_idle();
    release_input();
    wait_segments_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three timing registers plus one to the unused index
  task automatic program_timing(input logic [15:0] dot, input logic [15:0] dash,
                                input logic [15:0] gap, input logic [15:0] junk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DOT_TIME;
    cfg_wdata <= dot;
    @(posedge clk_i);
    cfg_idx   <= REG_DASH_TIME;
    cfg_wdata <= dash;
    @(posedge clk_i);
    cfg_idx   <= REG_LETTER_GAP;
    cfg_wdata <= gap;
    @(posedge clk_i);
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    dot_model  = dot;
    dash_model = dash;
    gap_model  = gap;
  endtask

  function automatic logic [15:0] random_timing();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(2000, 1));
  endfunction

  // Mostly letters of either case, some arbitrary bytes
  function automatic logic [7:0] random_char();
    logic [7:0] c;
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    c = CHAR_LOWER_A + 8'($urandom_range(25));
    if ($urandom_range(1)) c = c - CASE_OFFSET;
    return c;
  endfunction

  // Reset timing registers still in force
  task automatic test_reset_timing();
    key_char("e");
    key_char("T");
    key_char("0");
    wait_idle();
  endtask

  // Character code edges with extreme register values
  task automatic test_char_boundaries();
    logic [7:0] codes [12] = '{8'h00, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60,
                               8'h61, 8'h7A, 8'h7B, 8'h7F, 8'h80, 8'hFF};
    program_timing(16'd1, 16'hFFFF, 16'd0, 16'hFFFF);
    foreach (codes[i]) key_char(codes[i]);
    wait_idle();
  endtask

  // Zero dot and dash times, longest letter gap
  task automatic test_zero_durations();
    program_timing(16'd0, 16'd0, 16'hFFFF, 16'h1234);
    key_char("q");
    key_char("h");
    key_char("O");
    key_char("5");
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n, input int src_pct, input int dst_pct);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    program_timing(random_timing(), random_timing(), random_timing(),
                   16'($urandom));
    for (int i = 0; i < n; i++) begin
      // occasionally hold off until the output side has fully drained
      if ($urandom_range(19) == 0) begin
        release_input();
        wait_segments_done();
      end
      key_char(random_char());
    end
    wait_idle();
  endtask

  initial begin
    src_idle_pct = 26;
    dst_idle_pct = 69;
    dot_model    = DOT_TIME_RST;
    dash_model   = DASH_TIME_RST;
    gap_model    = LETTER_GAP_RST;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_timing();
    test_char_boundaries();
    test_zero_durations();
    test_random_traffic(34, 26, 69);
    test_random_traffic(34, 69, 26);
    test_random_traffic(34, 0, 0);

    if (pending_segs.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
